@@ hw/rtl/altitude_ema_vertical_speed_assert.svh @@
// Assertion macros used by the altitude smoother back end.
// Each macro expects signals named clk and rst in the module that uses it.
`ifndef ALTITUDE_EMA_VERTICAL_SPEED_ASSERT_SVH
`define ALTITUDE_EMA_VERTICAL_SPEED_ASSERT_SVH

`ifndef SYNTH

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define AEVS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("aevs assertion failed");

// Whenever the antecedent holds, the consequent holds in the next cycle.
`define AEVS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("aevs assertion failed");

// The condition never holds outside reset.
`define AEVS_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("aevs assertion failed");

`else

`define AEVS_ASSERT_IMPL(lbl, ante, cons)
`define AEVS_ASSERT_NEXT(lbl, ante, cons)
`define AEVS_ASSERT_NEVER(lbl, cond)

`endif

`endif

@@ hw/rtl/aevs_pkg.sv @@
// Shared widths, constants, codes and types of the altitude smoother.
// Used by every module of the block; depends on nothing.
package aevs_pkg;

  // Field widths of the stream payload.
  localparam int ALT_W    = 25;
  localparam int TIME_W   = 32;
  localparam int SPEED_W  = 21;

  // Fixed-point formats.
  localparam int FILTER_FRAC_BITS = 8;
  localparam int ALPHA_BITS       = 16;
  localparam int ALPHA_W          = ALPHA_BITS + 1;
  localparam int MIN_IV_W         = 20;
  localparam int X_W              = ALT_W + FILTER_FRAC_BITS;  // altitude in state
  localparam int DIFF_W           = X_W + 1;                   // difference of two
  localparam int PROD_W           = DIFF_W + ALPHA_W + 1;      // alpha times difference

  // Alpha clamp bounds: 0.01 and 1.0 in Q1.ALPHA_BITS.
  localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(2 ** ALPHA_BITS);
  localparam logic [ALPHA_W-1:0] ALPHA_MIN = ALPHA_W'((2 ** ALPHA_BITS + 50) / 100);
  localparam logic [PROD_W-1:0]  ROUND_HALF = PROD_W'(2 ** (ALPHA_BITS - 1));

  // 1e6 / 2^FILTER_FRAC_BITS reduces to SPEED_MUL / 2^DEN_SHIFT.
  localparam int SPEED_MUL_W = 14;
  localparam logic [SPEED_MUL_W-1:0] SPEED_MUL = 14'd15625;
  localparam int DEN_SHIFT   = 2;
  localparam int DEN_W       = TIME_W + DEN_SHIFT;
  localparam int SCALED_W    = DIFF_W + SPEED_MUL_W;

  // Divider quotient and saturation.
  localparam int QUOT_W     = 20;
  localparam logic [QUOT_W-1:0] SPEED_LIMIT = 20'd1000000;
  localparam int DIV_STEPS  = SCALED_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  // Request queue between front and back.
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = MIN_IV_W;
  localparam logic [CFG_IDX_W-1:0] REG_EMA_ALPHA    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_INTERVAL = 1'b1;
  localparam logic [ALPHA_W-1:0]   ALPHA_RESET      = 17'd6554;
  localparam logic [MIN_IV_W-1:0]  MIN_IV_RESET     = 20'd5000;

  // Stream payload widths.
  localparam int S_TDATA_W = 64;
  localparam int M_TDATA_W = 48;

  // One classified request as queued by the front.
  typedef struct packed {
    logic              reseed;
    logic [X_W-1:0]    x;     // altitude scaled by 2^FILTER_FRAC_BITS, signed
    logic [TIME_W-1:0] t;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quot;
  } div_status_t;

  typedef struct packed {
    logic               valid;
    logic [ALT_W-1:0]   filtered;
    logic [SPEED_W-1:0] speed;
    logic               skip;
  } result_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_UPD,
    BK_CHK,
    BK_SCALE,
    BK_START,
    BK_DIV,
    BK_DONE
  } bk_state_t;

endpackage

@@ hw/rtl/aevs_front.sv @@
// Front end: takes stream requests, scales the altitude and queues them.
// Depends on aevs_pkg.
module aevs_front
  import aevs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,
  input  logic                 s_tuser,
  input  logic                 pop,
  output q_head_t              head
);

  item_t               entries [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic                push;
  logic                take;
  item_t               incoming;

  // Classify the request and scale the altitude into the filter format.
  always_comb begin
    incoming.reseed = s_tuser;
    incoming.x      = {s_tdata[ALT_W-1:0], {FILTER_FRAC_BITS{1'b0}}};
    incoming.t      = s_tdata[ALT_W +: TIME_W];
  end

  assign s_tready = (count != QCNT_W'(QDEPTH));
  assign push     = s_tvalid && s_tready;
  assign take     = pop && (count != '0);

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (take) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + QCNT_W'(push) - QCNT_W'(take);
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= incoming;
    end
  end

  assign head.valid = (count != '0);
  assign head.item  = entries[rd_ptr];

endmodule

@@ hw/rtl/aevs_div.sv @@
// Restoring divider, one quotient bit per cycle, saturated to the speed limit.
// Depends on aevs_pkg.
module aevs_div
  import aevs_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [SCALED_W-1:0] dividend,
  input  logic [DEN_W-1:0]    divisor,
  output div_status_t         status
);

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [SCALED_W-1:0]  num;
  logic [DEN_W-1:0]     den;
  logic [DEN_W-1:0]     rem;
  logic [QUOT_W:0]      quot;
  logic                 ovf;
  logic [DEN_W:0]       rem_sh;
  logic [DEN_W+1:0]     sub;
  logic                 ge;

  // One trial subtraction per step.
  always_comb begin
    rem_sh = {rem, num[SCALED_W-1]};
    sub    = {1'b0, rem_sh} - {2'b00, den};
    ge     = !sub[DEN_W+1];
  end

  // Step control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(DIV_STEPS - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Remainder, dividend and quotient; bits pushed out of the quotient mark overflow.
  always_ff @(posedge clk) begin
    if (start) begin
      num  <= dividend;
      den  <= divisor;
      rem  <= '0;
      quot <= '0;
      ovf  <= 1'b0;
    end else if (busy) begin
      num  <= {num[SCALED_W-2:0], 1'b0};
      rem  <= ge ? sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      quot <= {quot[QUOT_W-1:0], ge};
      ovf  <= ovf | quot[QUOT_W];
    end
  end

  assign status.done = done;
  assign status.quot = (ovf || (quot > {1'b0, SPEED_LIMIT})) ? SPEED_LIMIT
                                                              : quot[QUOT_W-1:0];

endmodule

@@ hw/rtl/aevs_back.sv @@
// Back end: filter update, interval check and speed computation per request.
// Depends on aevs_pkg, aevs_div and the assertion macro header.
`include "altitude_ema_vertical_speed_assert.svh"

module aevs_back
  import aevs_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic [ALPHA_W-1:0]  alpha,
  input  logic [MIN_IV_W-1:0] min_interval,
  input  q_head_t             head,
  output logic                pop,
  output result_t             res,
  input  logic                res_take
);

  bk_state_t            state;
  bk_state_t            state_next;
  logic                 seeded;
  logic [X_W-1:0]       filt;
  logic [X_W-1:0]       last_alt;
  logic [TIME_W-1:0]    last_time;
  logic [TIME_W-1:0]    cur_time;
  logic [DIFF_W-1:0]    diff;
  logic [PROD_W-1:0]    prod;
  logic [TIME_W-1:0]    dt;
  logic [DIFF_W-1:0]    absd;
  logic                 neg;
  logic [SCALED_W-1:0]  scaled;
  logic [SPEED_W-1:0]   speed;
  logic                 skip;
  logic                 seed_now;
  logic                 too_short;
  logic                 div_start;
  logic [PROD_W-1:0]    step;
  logic [DIFF_W-1:0]    delta;
  logic [DIFF_W-1:0]    mm_sum;
  logic [DIFF_W-1:0]    mm_full;
  div_status_t          div_st;

  assign seed_now  = head.item.reseed || !seeded;
  assign too_short = (dt == '0) || (dt < {{(TIME_W-MIN_IV_W){1'b0}}, min_interval});

  // Rounded filter step, halves toward plus infinity.
  assign step  = $signed(prod + ROUND_HALF) >>> ALPHA_BITS;
  // Filter change since the last speed estimate.
  assign delta = {filt[X_W-1], filt} - {last_alt[X_W-1], last_alt};

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and control outputs.
  always_comb begin
    state_next = state;
    pop        = 1'b0;
    div_start  = 1'b0;
    case (state)
      BK_IDLE: begin
        if (head.valid) begin
          pop        = 1'b1;
          state_next = seed_now ? BK_DONE : BK_MUL;
        end
      end
      BK_MUL:   state_next = BK_UPD;
      BK_UPD:   state_next = BK_CHK;
      BK_CHK:   state_next = too_short ? BK_DONE : BK_SCALE;
      BK_SCALE: state_next = BK_START;
      BK_START: begin
        div_start  = 1'b1;
        state_next = BK_DIV;
      end
      BK_DIV: begin
        if (div_st.done) begin
          state_next = BK_DONE;
        end
      end
      BK_DONE: begin
        if (res_take) begin
          state_next = BK_IDLE;
        end
      end
      default:  state_next = BK_IDLE;
    endcase
  end

  // Filter state and datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      seeded <= 1'b0;
    end else begin
      case (state)
        BK_IDLE: begin
          if (head.valid) begin
            cur_time <= head.item.t;
            diff     <= {head.item.x[X_W-1], head.item.x} - {filt[X_W-1], filt};
            if (seed_now) begin
              filt      <= head.item.x;
              last_alt  <= head.item.x;
              last_time <= head.item.t;
              seeded    <= 1'b1;
              speed     <= '0;
              skip      <= 1'b0;
            end
          end
        end
        BK_MUL: begin
          prod <= PROD_W'($signed({1'b0, alpha}) * $signed(diff));
        end
        BK_UPD: begin
          filt <= filt + step[X_W-1:0];
          dt   <= cur_time - last_time;
        end
        BK_CHK: begin
          if (too_short) begin
            skip  <= 1'b1;
            speed <= '0;
          end else begin
            skip      <= 1'b0;
            last_alt  <= filt;
            last_time <= cur_time;
            neg       <= delta[DIFF_W-1];
            absd      <= delta[DIFF_W-1] ? (~delta + 1'b1) : delta;
          end
        end
        BK_SCALE: begin
          scaled <= absd * SPEED_MUL;
        end
        BK_DIV: begin
          if (div_st.done) begin
            speed <= neg ? (~{1'b0, div_st.quot} + 1'b1) : {1'b0, div_st.quot};
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Speed divider: |delta| * SPEED_MUL / (dt * 2^DEN_SHIFT).
  aevs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (scaled),
    .divisor  ({dt, {DEN_SHIFT{1'b0}}}),
    .status   (div_st)
  );

  // Whole millimetres, halves toward plus infinity.
  assign mm_sum  = {filt[X_W-1], filt} + DIFF_W'(2 ** (FILTER_FRAC_BITS - 1));
  assign mm_full = $signed(mm_sum) >>> FILTER_FRAC_BITS;

  assign res.valid    = (state == BK_DONE);
  assign res.filtered = mm_full[ALT_W-1:0];
  assign res.speed    = speed;
  assign res.skip     = skip;

  // Checks on the sequencing and the result.
  `AEVS_ASSERT_IMPL(a_pop_only_idle, pop, (state == BK_IDLE) && head.valid)
  `AEVS_ASSERT_IMPL(a_skip_zero_speed, res.valid && res.skip, res.speed == '0)
  `AEVS_ASSERT_IMPL(a_speed_limit, res.valid, ($signed(res.speed) <= 21'sd1000000) && ($signed(res.speed) >= -21'sd1000000))
  `AEVS_ASSERT_NEXT(a_div_wait, div_start, state == BK_DIV)
  `AEVS_ASSERT_NEVER(a_done_outside_div, div_st.done && (state != BK_DIV))

endmodule

@@ hw/rtl/altitude_ema_vertical_speed.sv @@
// Top level of the altitude smoother with climb-rate estimate.
// Depends on aevs_pkg, aevs_front and aevs_back.
//
//   channel   direction  signals                          per request
//   s_*       in         tvalid tready tdata[64] tuser    one altitude sample
//   m_*       out        tvalid tready tdata[48] tuser    one filtered result
//   cfg_*     in         we index[1] wdata[20]            one register write
//
// A seeding request skips the filter update and a short-interval request
// skips the speed estimate; a request with a speed estimate spends most of
// its time in the 48-step divider, which sets the rate.
// Up to two requests wait in the front queue while the back end is busy.
// One result waits in the output register; the back end stalls while it is full.
// Reset is synchronous; it clears the filter, so the next sample seeds it.
module altitude_ema_vertical_speed
  import aevs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // Input stream.
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // raw_altitude_mm[24:0], sample_time_us[56:25]
  input  logic                 s_tuser,   // req_type
  // Output stream.
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,   // filtered_altitude_mm[24:0],
                                          // vertical_speed_mm_s[45:25]
  output logic                 m_tuser,   // interval_too_short
  // Configuration writes.
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  logic [ALPHA_W-1:0]  alpha_reg;
  logic [MIN_IV_W-1:0] min_iv_reg;
  logic [ALPHA_W-1:0]  alpha_use;
  q_head_t             head;
  logic                pop;
  result_t             res;
  logic                res_take;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_reg  <= ALPHA_RESET;
      min_iv_reg <= MIN_IV_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_EMA_ALPHA:    alpha_reg  <= cfg_wdata[ALPHA_W-1:0];
        REG_MIN_INTERVAL: min_iv_reg <= cfg_wdata[MIN_IV_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Filter weight is held between 0.01 and 1.0.
  always_comb begin
    if (alpha_reg < ALPHA_MIN) begin
      alpha_use = ALPHA_MIN;
    end else if (alpha_reg > ALPHA_ONE) begin
      alpha_use = ALPHA_ONE;
    end else begin
      alpha_use = alpha_reg;
    end
  end

  aevs_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .pop      (pop),
    .head     (head)
  );

  aevs_back u_back (
    .clk          (clk),
    .rst          (rst),
    .alpha        (alpha_use),
    .min_interval (min_iv_reg),
    .head         (head),
    .pop          (pop),
    .res          (res),
    .res_take     (res_take)
  );

  assign res_take = res.valid && (!m_tvalid || m_tready);

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_take) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      m_tdata <= {{(M_TDATA_W - ALT_W - SPEED_W){1'b0}}, res.speed, res.filtered};
      m_tuser <= res.skip;
    end
  end

endmodule
